/* rtl/xs256_pkg.sv */
// shared types, constants and step functions of the xoshiro256** generator
package xs256_pkg;

	localparam int unsigned WORD_W      = 64;
	localparam int unsigned OP_W        = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_RAW     = 3'd0;
	localparam logic [OP_W-1:0] OP_RANGED  = 3'd1;
	localparam logic [OP_W-1:0] OP_SAVE    = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTORE = 3'd3;
	localparam logic [OP_W-1:0] OP_JUMP    = 3'd4;
	localparam logic [OP_W-1:0] OP_SEED    = 3'd5;

	// jump polynomial, word 0 in the low bits
	localparam logic [255:0] JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};

	localparam int unsigned SHIFT_T = 17;
	localparam int unsigned ROT_S3  = 45;
	localparam int unsigned ROT_OUT = 7;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0] state_t;

	// queued command after classification
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            inv;
		word_t           lo;
		word_t           span;
	} cmd_t;

	function automatic word_t rotl(input word_t x, input int unsigned k);
		return (x << k) | (x >> (WORD_W - k));
	endfunction

	// one generator step
	function automatic state_t advance(input state_t s);
		state_t n;
		word_t  t;
		t    = s[1] << SHIFT_T;
		n    = s;
		n[2] = s[2] ^ s[0];
		n[3] = s[3] ^ s[1];
		n[1] = s[1] ^ n[2];
		n[0] = s[0] ^ n[3];
		n[2] = n[2] ^ t;
		n[3] = rotl(n[3], ROT_S3);
		return n;
	endfunction

	// x * 5 as shift and add
	function automatic word_t mul5(input word_t x);
		return x + (x << 2);
	endfunction

	// rotl(p, 7) * 9 as shift and add
	function automatic word_t scramble_tail(input word_t p);
		word_t r;
		r = rotl(p, ROT_OUT);
		return r + (r << 3);
	endfunction

endpackage

/* rtl/xs256_front.sv */
// command front end: classifies accepted items into a short queue
module xs256_front import xs256_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  word_t             range_min,
	input  word_t             range_max,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              new_cmd;
	logic              push;
	logic              pop;

	assign busy      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entries_q[rd_ptr_q];

	// bounds check and span worked out once at entry
	always_comb begin
		new_cmd.op   = op;
		new_cmd.inv  = (range_min > range_max);
		new_cmd.lo   = range_min;
		new_cmd.span = range_max - range_min + word_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

/* rtl/xs256_mod_div.sv */
// bit-serial remainder unit: (dividend mod divisor) + offset
module xs256_mod_div import xs256_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t divisor,
	input  word_t offset,
	output logic  done,
	output word_t result
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_STEP = 3'b010,
		D_ADD  = 3'b100
	} dstate_t;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	dstate_t          st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	word_t            dvd_q;
	word_t            dvs_q;
	word_t            off_q;
	word_t            rem_q;
	word_t            result_q;
	logic [WORD_W:0]  shifted;
	word_t            diff;
	logic             take;

	assign shifted = {rem_q, dvd_q[WORD_W-1]};
	// when taken the difference is below the divisor, so the low bits suffice
	assign diff    = shifted[WORD_W-1:0] - dvs_q;
	assign take    = (shifted >= {1'b0, dvs_q});
	assign done    = done_q;
	assign result  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q  <= D_STEP;
						cnt_q <= '0;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						st_q <= D_ADD;
					end
				end
				D_ADD: begin
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					dvd_q <= dividend;
					dvs_q <= divisor;
					off_q <= offset;
					rem_q <= '0;
				end
			end
			D_STEP: begin
				rem_q <= take ? diff : shifted[WORD_W-1:0];
				dvd_q <= dvd_q << 1;
			end
			D_ADD: result_q <= rem_q + off_q;
			default: ;
		endcase
	end

endmodule

/* rtl/xs256_back.sv */
// execution back end: generator state, saved copy, jump sequencer, result register
module xs256_back import xs256_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  cmd_t  cmd,
	output logic  cmd_pop,
	input  state_t seed,
	output logic  div_start,
	output word_t div_dividend,
	output word_t div_divisor,
	output word_t div_offset,
	input  logic  div_done,
	input  word_t div_result,
	output logic  done,
	output word_t value,
	output logic  range_error
);

	typedef enum logic [2:0] {
		B_RUN  = 3'b001,
		B_WAIT = 3'b010,
		B_JUMP = 3'b100
	} bstate_t;

	bstate_t         bst_q;
	state_t          gen_q;
	state_t          saved_q;
	state_t          acc_q;
	state_t          acc_next;
	logic [7:0]      jcnt_q;
	logic            v_s1;
	logic [OP_W-1:0] op_s1;
	logic            inv_s1;
	word_t           lo_s1;
	word_t           span_s1;
	word_t           p5_s1;
	word_t           raw_s1;
	logic            special_s1;
	logic            done_q;
	logic            err_q;
	word_t           value_q;
	logic            div_start_q;
	word_t           div_dvd_q;
	word_t           div_dvs_q;
	word_t           div_off_q;

	assign cmd_pop      = cmd_valid && (bst_q == B_RUN);
	assign raw_s1       = scramble_tail(p5_s1);
	// inverted bounds or the full 64-bit interval skip the reduction
	assign special_s1   = inv_s1 || (span_s1 == '0);
	assign acc_next     = JUMP_POLY[jcnt_q] ? (acc_q ^ gen_q) : acc_q;
	assign done         = done_q;
	assign value        = value_q;
	assign range_error  = err_q;
	assign div_start    = div_start_q;
	assign div_dividend = div_dvd_q;
	assign div_divisor  = div_dvs_q;
	assign div_offset   = div_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_RUN;
			gen_q       <= {word_t'(0), word_t'(0), word_t'(0), word_t'(1)};
			saved_q     <= '0;
			jcnt_q      <= '0;
			v_s1        <= 1'b0;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			v_s1        <= 1'b0;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			case (bst_q)
				B_RUN: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_RAW: begin
								gen_q <= advance(gen_q);
								v_s1  <= 1'b1;
							end
							OP_RANGED: begin
								gen_q <= advance(gen_q);
								v_s1  <= 1'b1;
								bst_q <= B_WAIT;
							end
							OP_SAVE: begin
								saved_q <= gen_q;
								v_s1    <= 1'b1;
							end
							OP_RESTORE: begin
								gen_q <= saved_q;
								v_s1  <= 1'b1;
							end
							OP_SEED: begin
								gen_q <= seed;
								v_s1  <= 1'b1;
							end
							OP_JUMP: begin
								jcnt_q <= '0;
								bst_q  <= B_JUMP;
							end
							default: v_s1 <= 1'b1;
						endcase
					end
				end
				B_WAIT: begin
					if (div_done) begin
						bst_q <= B_RUN;
					end else if (v_s1 && special_s1) begin
						bst_q <= B_RUN;
					end
				end
				B_JUMP: begin
					jcnt_q <= jcnt_q + 1'b1;
					if (&jcnt_q) begin
						gen_q <= acc_next;
						v_s1  <= 1'b1;
						bst_q <= B_RUN;
					end else begin
						gen_q <= advance(gen_q);
					end
				end
				default: bst_q <= B_RUN;
			endcase

			// result stage
			if (v_s1) begin
				if (op_s1 == OP_RANGED && !special_s1) begin
					div_start_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end
			if (div_done) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_s1   <= cmd.op;
			inv_s1  <= cmd.inv;
			lo_s1   <= cmd.lo;
			span_s1 <= cmd.span;
			p5_s1   <= mul5(gen_q[1]);
			if (cmd.op == OP_JUMP) begin
				acc_q <= '0;
			end
		end
		if (bst_q == B_JUMP) begin
			acc_q <= acc_next;
			if (&jcnt_q) begin
				op_s1 <= OP_JUMP;
			end
		end
		if (v_s1) begin
			case (op_s1)
				OP_RAW: begin
					value_q <= raw_s1;
					err_q   <= 1'b0;
				end
				OP_RANGED: begin
					value_q   <= raw_s1;
					err_q     <= inv_s1;
					div_dvd_q <= raw_s1;
					div_dvs_q <= span_s1;
					div_off_q <= lo_s1;
				end
				default: begin
					value_q <= '0;
					err_q   <= 1'b0;
				end
			endcase
		end
		if (div_done) begin
			value_q <= div_result;
			err_q   <= 1'b0;
		end
	end

endmodule

/* rtl/xoshiro256_starstar_generator_core.sv */
// top level of the xoshiro256** generator core with save, restore, jump and reseed
// flow: an accepted item is queued, then popped into the back end's s1 stage, and
//   its done strobe is registered; a ranged draw goes through the serial remainder unit
// throughput: one item a cycle while the back end runs; a ranged draw holds it until its
//   reduction ends or is skipped, a jump for one generator step per polynomial bit
// reset: seeds 1,0,0,0, state to the seeds, saved copy zero, queue empty; no receiver stall
module xoshiro256_starstar_generator_core import xs256_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	// item input
	input  logic            start,
	output logic            busy,
	input  logic [OP_W-1:0] op,
	input  word_t           range_min,
	input  word_t           range_max,
	// seed register write port
	input  logic            cfg_write,
	input  logic [1:0]      cfg_index,
	input  word_t           cfg_data,
	// result output
	output logic            done,
	output word_t           value,
	output logic            range_error
);

	// seed registers, copied into the generator by the seed load operation
	state_t seed_q;

	// queue between front and back
	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;

	// remainder unit hookup
	logic  div_start;
	word_t div_dividend;
	word_t div_divisor;
	word_t div_offset;
	logic  div_done;
	word_t div_result;

	// register index maps straight onto the seed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= {word_t'(0), word_t'(0), word_t'(0), word_t'(1)};
		end else if (cfg_write) begin
			seed_q[cfg_index] <= cfg_data;
		end
	end

	// front: takes an item whenever the queue has room, checks bounds and span
	xs256_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.range_min (range_min),
		.range_max (range_max),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: steps the generator, runs jumps, orders results
	xs256_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.seed         (seed_q),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_offset   (div_offset),
		.div_done     (div_done),
		.div_result   (div_result),
		.done         (done),
		.value        (value),
		.range_error  (range_error)
	);

	// one remainder bit per cycle for ranged draws
	xs256_mod_div u_mod_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.offset   (div_offset),
		.done     (div_done),
		.result   (div_result)
	);

endmodule
